[rtl/rfte_pkg.sv]
`default_nettype none

package rfte_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_BINARY_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOUR_12_MODE = 2'd1;

	// Days from 1970-01-01 to 2000-01-01.
	localparam logic [15:0] DAYS_TO_2000 = 16'd10957;

	typedef struct packed {
		logic       binary_mode;
		logic       hour_12_mode;
	} cfg_t;

	typedef struct packed {
		logic [7:0] hour_raw;
		logic [7:0] minute_raw;
		logic [7:0] second_raw;
		logic [7:0] day_raw;
		logic [7:0] month_raw;
		logic [7:0] year_raw;
	} raw_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [7:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic       bad;
	} fields_t;

	typedef struct packed {
		logic [15:0] days;
		logic [16:0] sod;
		logic        bad;
	} daycount_t;

	typedef struct packed {
		logic [31:0] secs;
		logic        bad;
	} secs_t;

	typedef struct packed {
		logic [41:0] timestamp_ms;
		logic        field_error;
	} result_t;

	// Returns {bad_digit, value}. In binary mode the byte passes unchanged.
	function automatic logic [8:0] decode_byte(input logic [7:0] raw, input logic binary);
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] val;
		logic       bad;
		hi  = {4'd0, raw[7:4]};
		lo  = {4'd0, raw[3:0]};
		val = {hi[4:0], 3'b000} + {hi[6:0], 1'b0} + lo;
		bad = (raw[7:4] > 4'd9) || (raw[3:0] > 4'd9);
		if (binary) begin
			decode_byte = {1'b0, raw};
		end else begin
			decode_byte = {bad, val};
		end
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		case (month)
			4'd2:    month_len = leap ? 5'd29 : 5'd28;
			4'd4:    month_len = 5'd30;
			4'd6:    month_len = 5'd30;
			4'd9:    month_len = 5'd30;
			4'd11:   month_len = 5'd30;
			default: month_len = 5'd31;
		endcase
	endfunction

	// Days in the year before the first of the given month, common year.
	function automatic logic [8:0] cum_days(input logic [3:0] month);
		case (month)
			4'd1:    cum_days = 9'd0;
			4'd2:    cum_days = 9'd31;
			4'd3:    cum_days = 9'd59;
			4'd4:    cum_days = 9'd90;
			4'd5:    cum_days = 9'd120;
			4'd6:    cum_days = 9'd151;
			4'd7:    cum_days = 9'd181;
			4'd8:    cum_days = 9'd212;
			4'd9:    cum_days = 9'd243;
			4'd10:   cum_days = 9'd273;
			4'd11:   cum_days = 9'd304;
			4'd12:   cum_days = 9'd334;
			default: cum_days = 9'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

[rtl/rfte_in_if.sv]
`default_nettype none

interface rfte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] hour_raw;
	logic [7:0] minute_raw;
	logic [7:0] second_raw;
	logic [7:0] day_raw;
	logic [7:0] month_raw;
	logic [7:0] year_raw;

	modport source (
		output valid, hour_raw, minute_raw, second_raw, day_raw, month_raw, year_raw,
		input  ready
	);
	modport sink (
		input  valid, hour_raw, minute_raw, second_raw, day_raw, month_raw, year_raw,
		output ready
	);
endinterface

`default_nettype wire

[rtl/rfte_out_if.sv]
`default_nettype none

interface rfte_out_if;
	logic        valid;
	logic        ready;
	logic [41:0] timestamp_ms;
	logic        field_error;

	modport source (
		output valid, timestamp_ms, field_error,
		input  ready
	);
	modport sink (
		input  valid, timestamp_ms, field_error,
		output ready
	);
endinterface

`default_nettype wire

[rtl/rfte_cfg_if.sv]
`default_nettype none

interface rfte_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rfte_pkg::CFG_IDX_W-1:0]  index;
	logic [rfte_pkg::CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

[rtl/rfte_decode.sv]
`default_nettype none

module rfte_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire rfte_pkg::raw_t  raw,
	input  wire rfte_pkg::cfg_t  cfg,
	output logic                 valid_s1,
	output rfte_pkg::fields_t    fields_s1
);

	logic [7:0]        hraw;
	logic              pm;
	logic [8:0]        hdec, mdec, sdec, ddec, modec, ydec;
	logic [7:0]        h;
	logic [7:0]        hadj;
	logic              hbad;
	rfte_pkg::fields_t nxt;

	always_comb begin
		hraw  = cfg.hour_12_mode ? {1'b0, raw.hour_raw[6:0]} : raw.hour_raw;
		pm    = cfg.hour_12_mode & raw.hour_raw[7];
		hdec  = rfte_pkg::decode_byte(hraw, cfg.binary_mode);
		mdec  = rfte_pkg::decode_byte(raw.minute_raw, cfg.binary_mode);
		sdec  = rfte_pkg::decode_byte(raw.second_raw, cfg.binary_mode);
		ddec  = rfte_pkg::decode_byte(raw.day_raw, cfg.binary_mode);
		modec = rfte_pkg::decode_byte(raw.month_raw, cfg.binary_mode);
		ydec  = rfte_pkg::decode_byte(raw.year_raw, cfg.binary_mode);
		h     = hdec[7:0];

		// 12 AM maps to hour 0; PM adds twelve, so 12 PM stays at 12.
		if (cfg.hour_12_mode) begin
			hbad = (h < 8'd1) || (h > 8'd12);
			hadj = ((h == 8'd12) ? 8'd0 : h) + (pm ? 8'd12 : 8'd0);
		end else begin
			hbad = h > 8'd23;
			hadj = h;
		end

		nxt.hour   = hadj[4:0];
		nxt.minute = mdec[5:0];
		nxt.second = sdec[5:0];
		nxt.day    = ddec[7:0];
		nxt.month  = modec[3:0];
		nxt.year   = ydec[6:0];
		nxt.bad    = hdec[8] | mdec[8] | sdec[8] | ddec[8] | modec[8] | ydec[8] | hbad
			| (mdec[7:0] > 8'd59) | (sdec[7:0] > 8'd59) | (ydec[7:0] > 8'd99)
			| (modec[7:0] < 8'd1) | (modec[7:0] > 8'd12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fields_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/rfte_calendar.sv]
`default_nettype none

module rfte_calendar (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_s1,
	input  wire rfte_pkg::fields_t fields_s1,
	output logic                   valid_s2,
	output rfte_pkg::daycount_t    count_s2
);

	logic                leap;
	logic [4:0]          mlen;
	logic                day_bad;
	logic [15:0]         yr_days;
	logic [7:0]          leap_sum;
	logic [15:0]         leaps;
	logic [15:0]         extra;
	logic [15:0]         days;
	logic [16:0]         sod;
	rfte_pkg::daycount_t nxt;

	always_comb begin
		// Within 2000..2099 a year is leap exactly when its two digits divide by four.
		leap     = fields_s1.year[1:0] == 2'd0;
		mlen     = rfte_pkg::month_len(fields_s1.month, leap);
		day_bad  = (fields_s1.day == 8'd0) || (fields_s1.day > {3'd0, mlen});
		yr_days  = {9'd0, fields_s1.year} * 16'd365;
		// Leap years from 2000 up to the year before this one.
		leap_sum = {1'b0, fields_s1.year} + 8'd3;
		leaps    = {10'd0, leap_sum[7:2]};
		extra    = {15'd0, leap && (fields_s1.month > 4'd2)};
		days     = rfte_pkg::DAYS_TO_2000 + yr_days + leaps
			+ {7'd0, rfte_pkg::cum_days(fields_s1.month)} + extra
			+ {11'd0, fields_s1.day[4:0]} - 16'd1;
		sod      = {12'd0, fields_s1.hour} * 17'd3600 + {11'd0, fields_s1.minute} * 17'd60
			+ {11'd0, fields_s1.second};

		nxt.days = days;
		nxt.sod  = sod;
		nxt.bad  = fields_s1.bad | day_bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			count_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/rfte_scale.sv]
`default_nettype none

module rfte_scale (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en_s3,
	input  wire logic                en_s4,
	input  wire logic                valid_s2,
	input  wire rfte_pkg::daycount_t count_s2,
	output logic                     valid_s3,
	output logic                     valid_s4,
	output rfte_pkg::result_t        result_s4
);

	rfte_pkg::secs_t   secs_s3;
	logic [31:0]       secs_nxt;
	logic [41:0]       ms_nxt;
	rfte_pkg::result_t res_nxt;

	always_comb begin
		secs_nxt = {16'd0, count_s2.days} * 32'd86400 + {15'd0, count_s2.sod};
		ms_nxt   = {10'd0, secs_s3.secs} * 42'd1000;
		res_nxt.timestamp_ms = secs_s3.bad ? 42'd0 : ms_nxt;
		res_nxt.field_error  = secs_s3.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			secs_s3.secs <= secs_nxt;
			secs_s3.bad  <= count_s2.bad;
		end
		if (en_s4) begin
			result_s4 <= res_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/rtc_fields_to_epoch_ms.sv]
`default_nettype none

// Channel  Role    Payload
// rtc_in   sink    hour_raw, minute_raw, second_raw, day_raw, month_raw, year_raw
// epoch    source  timestamp_ms (42 bits), field_error
// cfg      sink    index (2 bits), data (8 bits, bit 0 used); always ready
//
// Four register stages: decode, calendar, seconds multiply, milliseconds multiply.
// A result passes through these stages in order after its input transfer; one item
// per cycle while the output is not stalled.
// Reset clears every stage valid and both configuration bits.
// A stage loads when it is empty or the stage after it moves, so a stall on the
// output backs up stage by stage while bubbles are squeezed out.

module rtc_fields_to_epoch_ms (
	input wire logic   clk,
	input wire logic   arst_n,
	rfte_in_if.sink    rtc_in,
	rfte_out_if.source epoch,
	rfte_cfg_if.sink   cfg
);

	rfte_pkg::cfg_t      cfg_q;
	rfte_pkg::raw_t      raw;
	rfte_pkg::fields_t   fields_s1;
	rfte_pkg::daycount_t count_s2;
	rfte_pkg::result_t   result_s4;
	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic                en_s1, en_s2, en_s3, en_s4;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				rfte_pkg::CFG_BINARY_MODE:  cfg_q.binary_mode  <= cfg.data[0];
				rfte_pkg::CFG_HOUR_12_MODE: cfg_q.hour_12_mode <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign en_s4 = !valid_s4 || epoch.ready;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign rtc_in.ready = en_s1;

	assign raw.hour_raw   = rtc_in.hour_raw;
	assign raw.minute_raw = rtc_in.minute_raw;
	assign raw.second_raw = rtc_in.second_raw;
	assign raw.day_raw    = rtc_in.day_raw;
	assign raw.month_raw  = rtc_in.month_raw;
	assign raw.year_raw   = rtc_in.year_raw;

	rfte_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_s1),
		.in_valid  (rtc_in.valid),
		.raw       (raw),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.fields_s1 (fields_s1)
	);

	rfte_calendar u_calendar (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_s2),
		.valid_s1  (valid_s1),
		.fields_s1 (fields_s1),
		.valid_s2  (valid_s2),
		.count_s2  (count_s2)
	);

	rfte_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en_s3     (en_s3),
		.en_s4     (en_s4),
		.valid_s2  (valid_s2),
		.count_s2  (count_s2),
		.valid_s3  (valid_s3),
		.valid_s4  (valid_s4),
		.result_s4 (result_s4)
	);

	assign epoch.valid        = valid_s4;
	assign epoch.timestamp_ms = result_s4.timestamp_ms;
	assign epoch.field_error  = result_s4.field_error;

	// The input is held off only when every stage holds an item.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rtc_in.ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("input stalled while the pipeline has a free stage");

	a_error_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(epoch.valid && epoch.field_error) |-> (epoch.timestamp_ms == 42'd0))
		else $error("error result carries a nonzero timestamp");

	a_timestamp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		epoch.valid |-> (epoch.timestamp_ms < 42'd4102444800000))
		else $error("timestamp beyond the end of 2099");

	a_bubble_stays_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s3 && en_s4) |=> !valid_s4)
		else $error("result appeared without an item behind it");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !epoch.ready) |=> (valid_s4 && $stable(result_s4)))
		else $error("stalled result changed");

endmodule

`default_nettype wire
